@@ design/esb_pkg.sv @@
`default_nettype none

package esb_pkg;

    localparam int DATA_W  = 32;
    localparam int ORDER_W = 2;

    localparam logic [ORDER_W-1:0] ORDER_ASC  = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_DESC = 2'd1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SORT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
        logic     desc;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ design/esb_cell.sv @@
`default_nettype none

module esb_cell (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  esb_pkg::t_cell_ctl                   i_ctl,
    input  wire                                  i_parity,
    input  wire                                  i_wr_en,
    input  wire  signed [esb_pkg::DATA_W-1:0]    i_din,
    input  wire  signed [esb_pkg::DATA_W-1:0]    i_lo_val,
    input  wire                                  i_lo_vld,
    input  wire  signed [esb_pkg::DATA_W-1:0]    i_hi_val,
    input  wire                                  i_hi_vld,
    output logic signed [esb_pkg::DATA_W-1:0]    o_val,
    output logic                                 o_vld
);

    logic signed [esb_pkg::DATA_W-1:0] r_val, n_val;
    logic                              r_vld, n_vld;
    logic                              w_swap_hi, w_swap_lo;

    // pair (a below, b above): swap when b belongs before a
    always_comb begin
        w_swap_hi = r_vld && i_hi_vld &&
                    (i_ctl.desc ? (r_val < i_hi_val) : (i_hi_val < r_val));
        w_swap_lo = r_vld && i_lo_vld &&
                    (i_ctl.desc ? (i_lo_val < r_val) : (r_val < i_lo_val));
    end

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        unique case (i_ctl.op)
            esb_pkg::CELL_HOLD: begin
            end
            esb_pkg::CELL_LOAD: begin
                if (i_wr_en) begin
                    n_val = i_din;
                    n_vld = 1'b1;
                end
            end
            esb_pkg::CELL_SORT: begin
                if (i_ctl.phase == i_parity) begin
                    if (w_swap_hi) begin
                        n_val = i_hi_val;
                    end
                end else begin
                    if (w_swap_lo) begin
                        n_val = i_lo_val;
                    end
                end
            end
            esb_pkg::CELL_SHIFT: begin
                n_val = i_hi_val;
                n_vld = i_hi_vld;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

`default_nettype wire

@@ design/exchange_sort_block.sv @@
// first result: a set closes with the item carrying last_in; with sorting it
//   follows the sort passes, with order kept it appears in the next cycle
// throughput: one item per cycle while loading, one result per cycle while
//   emitting and not stalled, with the odd-even sort passes per set between
// reset: synchronous active low, clears state, fill count, cell valid bits and
//   sort_order (ascending)
`default_nettype none

module exchange_sort_block #(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  signed [esb_pkg::DATA_W-1:0]  i_value,
    input  wire                                i_last_in,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic signed [esb_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                               o_last_out,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire         [esb_pkg::ORDER_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    esb_pkg::t_state                   r_state, n_state;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic [CNT_W-1:0]                  r_pass, n_pass;
    logic                              r_phase, n_phase;
    logic                              r_desc, n_desc;
    logic [esb_pkg::ORDER_W-1:0]       r_sort_order;
    esb_pkg::t_cell_ctl                w_ctl;
    logic                              w_in_acc, w_out_acc;

    logic signed [esb_pkg::DATA_W-1:0] w_val [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]           w_vld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_order <= esb_pkg::ORDER_ASC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sort_order <= i_cfg_data;
        end
    end

    assign o_in_stall     = (r_state != esb_pkg::ST_LOAD);
    assign w_in_acc       = i_in_valid && !o_in_stall;
    assign o_out_valid    = (r_state == esb_pkg::ST_EMIT) && w_vld[0];
    assign w_out_acc      = o_out_valid && !i_out_stall;
    assign o_sorted_value = w_val[0];
    assign o_last_out     = !w_vld[1];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pass    = r_pass;
        n_phase   = r_phase;
        n_desc    = r_desc;
        w_ctl.op    = esb_pkg::CELL_HOLD;
        w_ctl.phase = r_phase;
        w_ctl.desc  = r_desc;
        unique case (r_state)
            esb_pkg::ST_LOAD: begin
                if (w_in_acc) begin
                    w_ctl.op = esb_pkg::CELL_LOAD;
                    if (r_count != CNT_W'(MAX_ELEMENTS)) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_last_in) begin
                        n_pass  = '0;
                        n_phase = 1'b0;
                        n_desc  = (r_sort_order == esb_pkg::ORDER_DESC);
                        if (r_sort_order == esb_pkg::ORDER_ASC ||
                            r_sort_order == esb_pkg::ORDER_DESC) begin
                            n_state = esb_pkg::ST_SORT;
                        end else begin
                            n_state = esb_pkg::ST_EMIT;
                            n_count = '0;
                        end
                    end
                end
            end
            esb_pkg::ST_SORT: begin
                if (r_pass == r_count) begin
                    n_state = esb_pkg::ST_EMIT;
                    n_count = '0;
                end else begin
                    w_ctl.op = esb_pkg::CELL_SORT;
                    n_pass   = r_pass + 1'b1;
                    n_phase  = !r_phase;
                end
            end
            esb_pkg::ST_EMIT: begin
                if (w_out_acc) begin
                    w_ctl.op = esb_pkg::CELL_SHIFT;
                    if (o_last_out) begin
                        n_state = esb_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = esb_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pass  <= n_pass;
        r_phase <= n_phase;
        r_desc  <= n_desc;
        if (!i_rst_n) begin
            r_state <= esb_pkg::ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
            logic signed [esb_pkg::DATA_W-1:0] w_lo_val, w_hi_val;
            logic                              w_lo_vld, w_hi_vld;

            if (k == 0) begin : g_lo_edge
                assign w_lo_val = '0;
                assign w_lo_vld = 1'b0;
            end else begin : g_lo
                assign w_lo_val = w_val[k-1];
                assign w_lo_vld = w_vld[k-1];
            end

            if (k == MAX_ELEMENTS - 1) begin : g_hi_edge
                assign w_hi_val = '0;
                assign w_hi_vld = 1'b0;
            end else begin : g_hi
                assign w_hi_val = w_val[k+1];
                assign w_hi_vld = w_vld[k+1];
            end

            esb_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_parity (1'(k % 2)),
                .i_wr_en  (r_count == CNT_W'(k)),
                .i_din    (i_value),
                .i_lo_val (w_lo_val),
                .i_lo_vld (w_lo_vld),
                .i_hi_val (w_hi_val),
                .i_hi_vld (w_hi_vld),
                .o_val    (w_val[k]),
                .o_vld    (w_vld[k])
            );
        end
    endgenerate

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("fill count beyond capacity");

    a_last_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_last_out |=> r_state == esb_pkg::ST_LOAD && !w_vld[0])
        else $error("cells not empty after final result");

    a_close_leaves_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_last_in |=> r_state != esb_pkg::ST_LOAD && w_vld[0])
        else $error("closing item did not start output");

    a_sort_keeps_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == esb_pkg::ST_SORT && $past(r_state) == esb_pkg::ST_SORT
        |-> $stable(w_vld))
        else $error("sort pass changed cell occupancy");

endmodule

`default_nettype wire
